FILE: hw/rtl/nbmh_pkg.sv
// ----------------------------------------------------------------------------
// nbmh_pkg
// Shared types, constants and helpers of the nearest-bin mean histogram.
// ----------------------------------------------------------------------------
package nbmh_pkg;

    localparam int NUM_BINS_MAX    = 64;
    localparam int BIN_IDX_W       = $clog2(NUM_BINS_MAX);
    localparam int NB_W            = BIN_IDX_W + 1;
    localparam int TIME_W          = 32;
    localparam int PF_W            = 16;
    localparam int CNT_W           = 16;
    localparam int SUM_W           = 48;
    localparam int MAX_SET_SAMPLES = 65535;

    // Shared divider: a wide dividend for the mean, a short one for binning.
    localparam int DIV_N_W   = SUM_W;
    localparam int DIV_D_W   = PF_W + 1;
    localparam int DIV_SHORT = PF_W + 2;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [PF_W-1:0] PF_ORIGIN_RST = 16'd5870;
    localparam logic [PF_W-1:0] BIN_WIDTH_RST = 16'd186;
    localparam logic [NB_W-1:0] NUM_BINS_RST  = 7'd64;

    typedef enum logic [1:0] {
        REG_PF_ORIGIN = 2'd0,
        REG_BIN_WIDTH = 2'd1,
        REG_NUM_BINS  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [TIME_W-1:0] time_value;
        logic [PF_W-1:0]   pf_value;
        logic              set_end;
    } t_sample;

    typedef struct packed {
        logic [BIN_IDX_W-1:0] bin_index;
        logic [TIME_W-1:0]    mean_time;
        logic [CNT_W-1:0]     sample_count;
        logic                 last_bin;
    } t_result;

    typedef struct packed {
        logic [PF_W-1:0] pf_origin;
        logic [PF_W-1:0] bin_width;
        logic [NB_W-1:0] num_bins;
    } t_cfg;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } t_bin_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BIN_DIV,
        S_ACC,
        S_EMIT_RD,
        S_EMIT_DATA,
        S_EMIT_DIV
    } t_state;

    // Bin count actually used, clamped to 2..NUM_BINS_MAX.
    function automatic logic [NB_W-1:0] bins_in_use(input logic [NB_W-1:0] nb);
        logic [NB_W-1:0] res;
        res = nb;
        if (nb < NB_W'(2)) begin
            res = NB_W'(2);
        end else if (nb > NB_W'(NUM_BINS_MAX)) begin
            res = NB_W'(NUM_BINS_MAX);
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/nbmh_cfg.sv
// ----------------------------------------------------------------------------
// nbmh_cfg
// APB register file holding the pf origin, bin width and bin count.
// ----------------------------------------------------------------------------
module nbmh_cfg
    import nbmh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pf_origin <= PF_ORIGIN_RST;
            r_cfg.bin_width <= BIN_WIDTH_RST;
            r_cfg.num_bins  <= NUM_BINS_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_PF_ORIGIN: r_cfg.pf_origin <= pwdata[PF_W-1:0];
                REG_BIN_WIDTH: r_cfg.bin_width <= pwdata[PF_W-1:0];
                REG_NUM_BINS:  r_cfg.num_bins  <= pwdata[NB_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_PF_ORIGIN: prdata = APB_DW'(r_cfg.pf_origin);
            REG_BIN_WIDTH: prdata = APB_DW'(r_cfg.bin_width);
            REG_NUM_BINS:  prdata = APB_DW'(r_cfg.num_bins);
            default:       prdata = '0;
        endcase
    end

endmodule

FILE: hw/rtl/nbmh_div.sv
// ----------------------------------------------------------------------------
// nbmh_div
// Restoring divider, one quotient bit per cycle. Runs 48 steps for a mean
// or 18 steps for a bin index.
// ----------------------------------------------------------------------------
module nbmh_div
    import nbmh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_long,
    input  logic [DIV_N_W-1:0] i_dividend,
    input  logic [DIV_D_W-1:0] i_divisor,
    output logic               o_done,
    output logic [DIV_N_W-1:0] o_quotient
);

    logic [DIV_N_W-1:0]   r_quo;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_D_W-1:0]   r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;

    logic [DIV_D_W:0]     trial;
    logic                 fits;

    assign trial      = {r_rem, r_quo[DIV_N_W-1]};
    assign fits       = trial >= {1'b0, r_den};
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= i_long ? DIV_CNT_W'(DIV_N_W) : DIV_CNT_W'(DIV_SHORT);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // A short division starts with its dividend in the top bits, so the
    // quotient still ends up right-aligned.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_long ? i_dividend : (i_dividend << (DIV_N_W - DIV_SHORT));
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DIV_N_W-2:0], fits};
            r_rem <= fits ? DIV_D_W'(trial - {1'b0, r_den}) : trial[DIV_D_W-1:0];
        end
    end

endmodule

FILE: hw/rtl/nbmh_bin_ram.sv
// ----------------------------------------------------------------------------
// nbmh_bin_ram
// Bin store: sum and count per bin in one synchronous memory, with a valid
// bit per entry so the whole store clears with a single clear strobe.
// ----------------------------------------------------------------------------
module nbmh_bin_ram
    import nbmh_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    input  logic                 i_wr_en,
    input  logic [BIN_IDX_W-1:0] i_wr_addr,
    input  t_bin_entry           i_wr_data,
    input  logic                 i_rd_en,
    input  logic [BIN_IDX_W-1:0] i_rd_addr,
    output t_bin_entry           o_rd_data
);

    t_bin_entry              mem [NUM_BINS_MAX];
    logic [NUM_BINS_MAX-1:0] r_valid;
    t_bin_entry              r_rd_data;
    logic                    r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
            if (i_clear) begin
                r_valid <= '0;
            end else if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    // An entry never written since the last clear reads as an empty bin.
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

FILE: hw/rtl/nearest_bin_mean_histogram_core.sv
// ----------------------------------------------------------------------------
// nearest_bin_mean_histogram_core
// Sorts (time, pf) samples into nearest pf bins and reports per-bin means.
// ----------------------------------------------------------------------------
// Usage:
// A sample word on i_sample is taken at a clock edge with start high and busy
// low. Its pf selects a bin by rounded division by the bin width; in-range
// samples add their time to the bin sum and count in the bin memory.
// A plain sample keeps busy high through 18 steps of the shared bit-serial
// divider, a state that takes the quotient and reads the bin, and the
// write-back; one that misses every bin skips the read and write-back. The
// next word is taken only after busy has fallen.
// A sample with set_end high, after its own binning, reads out every bin in
// use in order. Each bin passes through a read state and a data state and,
// if not empty, a third state that waits for the 48-step mean division.
// Each result word is on o_result for one cycle with o_result_valid high;
// last_bin marks the final bin. The receiver cannot stall, so the block
// never waits on it. After the last bin the store is empty again and busy falls.
// Reset restores the register defaults and empties the store at once; a
// sample may be started in the first cycle after reset. The user writes
// registers over the APB port only while busy is low; nothing enforces it.
// ----------------------------------------------------------------------------
module nearest_bin_mean_histogram_core
    import nbmh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_sample           i_sample,
    output logic              o_result_valid,
    output t_result           o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg cfg;

    t_state               r_state, n_state;
    logic [TIME_W-1:0]    r_time, n_time;
    logic                 r_end, n_end;
    logic                 r_neg, n_neg;
    logic [BIN_IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0]     r_samples, n_samples;
    logic [CNT_W-1:0]     r_cnt_lat, n_cnt_lat;
    t_result              r_res, n_res;
    logic                 r_res_vld, n_res_vld;

    logic                 div_start, div_long, div_done;
    logic [DIV_N_W-1:0]   div_dividend, div_quotient;
    logic [DIV_D_W-1:0]   div_divisor;

    logic                 ram_clear, ram_wr_en, ram_rd_en;
    logic [BIN_IDX_W-1:0] ram_rd_addr;
    t_bin_entry           ram_wr_data, ram_rd_data;

    logic [NB_W-1:0]      nb;
    logic [PF_W-1:0]      w_eff, pf_mag;
    logic                 pf_neg;
    logic [PF_W+1:0]      bin_num;
    logic                 q_in_range;
    logic                 is_last;
    logic                 accept;

    nbmh_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    nbmh_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_long     (div_long),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    nbmh_bin_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (ram_clear),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign busy           = r_state != S_IDLE;
    assign accept         = start & ~busy;
    assign o_result_valid = r_res_vld;
    assign o_result       = r_res;

    // Bin index = round-half-away(|pf - origin| / w) = (2m + w) / (2w).
    assign nb      = bins_in_use(cfg.num_bins);
    assign w_eff   = (cfg.bin_width == '0) ? PF_W'(1) : cfg.bin_width;
    assign pf_neg  = i_sample.pf_value < cfg.pf_origin;
    assign pf_mag  = pf_neg ? (cfg.pf_origin - i_sample.pf_value)
                            : (i_sample.pf_value - cfg.pf_origin);
    assign bin_num = {1'b0, pf_mag, 1'b0} + (PF_W+2)'(w_eff);

    // Below the origin only a quotient of zero still counts as bin zero.
    assign q_in_range = r_neg ? (div_quotient == '0)
                              : ((div_quotient[DIV_N_W-1:BIN_IDX_W] == '0) &&
                                 ({1'b0, div_quotient[BIN_IDX_W-1:0]} < nb));
    assign is_last    = {1'b0, r_idx} == (nb - NB_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_samples <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_samples <= n_samples;
            r_res_vld <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_time    <= n_time;
        r_end     <= n_end;
        r_neg     <= n_neg;
        r_idx     <= n_idx;
        r_cnt_lat <= n_cnt_lat;
        r_res     <= n_res;
    end

    always_comb begin
        n_state      = r_state;
        n_time       = r_time;
        n_end        = r_end;
        n_neg        = r_neg;
        n_idx        = r_idx;
        n_samples    = r_samples;
        n_cnt_lat    = r_cnt_lat;
        n_res        = r_res;
        n_res_vld    = 1'b0;
        div_start    = 1'b0;
        div_long     = 1'b0;
        div_dividend = DIV_N_W'(bin_num);
        div_divisor  = {w_eff, 1'b0};
        ram_clear    = 1'b0;
        ram_wr_en    = 1'b0;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_idx;
        ram_wr_data.sum   = ram_rd_data.sum + SUM_W'(r_time);
        ram_wr_data.count = ram_rd_data.count + CNT_W'(1);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_time = i_sample.time_value;
                    n_end  = i_sample.set_end;
                    n_neg  = pf_neg;
                    n_idx  = '0;
                    if (r_samples < CNT_W'(MAX_SET_SAMPLES)) begin
                        n_samples = r_samples + CNT_W'(1);
                        div_start = 1'b1;
                        n_state   = S_BIN_DIV;
                    end else if (i_sample.set_end) begin
                        n_state = S_EMIT_RD;
                    end
                end
            end
            S_BIN_DIV: begin
                if (div_done) begin
                    n_idx = div_quotient[BIN_IDX_W-1:0];
                    if (q_in_range) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = div_quotient[BIN_IDX_W-1:0];
                        n_state     = S_ACC;
                    end else begin
                        n_idx   = '0;
                        n_state = r_end ? S_EMIT_RD : S_IDLE;
                    end
                end
            end
            S_ACC: begin
                // The bin read arrives here and goes back with this sample added.
                ram_wr_en = 1'b1;
                n_idx     = '0;
                n_state   = r_end ? S_EMIT_RD : S_IDLE;
            end
            S_EMIT_RD: begin
                ram_rd_en = 1'b1;
                n_state   = S_EMIT_DATA;
            end
            S_EMIT_DATA: begin
                n_cnt_lat    = ram_rd_data.count;
                n_res.bin_index    = r_idx;
                n_res.sample_count = ram_rd_data.count;
                n_res.last_bin     = is_last;
                if (ram_rd_data.count == '0) begin
                    n_res.mean_time = '0;
                    n_res_vld       = 1'b1;
                    n_idx           = r_idx + BIN_IDX_W'(1);
                    n_state         = S_EMIT_RD;
                    if (is_last) begin
                        ram_clear = 1'b1;
                        n_samples = '0;
                        n_state   = S_IDLE;
                    end
                end else begin
                    div_start    = 1'b1;
                    div_long     = 1'b1;
                    div_dividend = ram_rd_data.sum;
                    div_divisor  = DIV_D_W'(ram_rd_data.count);
                    n_state      = S_EMIT_DIV;
                end
            end
            S_EMIT_DIV: begin
                if (div_done) begin
                    n_res.mean_time    = div_quotient[TIME_W-1:0];
                    n_res.sample_count = r_cnt_lat;
                    n_res_vld          = 1'b1;
                    n_idx              = r_idx + BIN_IDX_W'(1);
                    n_state            = S_EMIT_RD;
                    if (is_last) begin
                        ram_clear = 1'b1;
                        n_samples = '0;
                        n_state   = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
